FILE: hw/rtl/world_to_viewport_projection_assert.svh
// Assertion macros shared by the projection checker
`ifndef WORLD_TO_VIEWPORT_PROJECTION_ASSERT_SVH
`define WORLD_TO_VIEWPORT_PROJECTION_ASSERT_SVH

// clocked assertion, aborted while reset is high
`define W2VP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define W2VP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/w2vp_pkg.sv
// Types, constants and the divider step for the world to viewport projection
`timescale 1ns / 1ps

package w2vp_pkg;

   localparam int CLIP_W    = 51;          // signed clip component
   localparam int D_W       = CLIP_W + 1;  // divisor 2w and dividend
   localparam int RR_W      = D_W + 1;     // partial remainder
   localparam int DIV_STEPS = 20;          // one per bit of dimension * 16
   localparam int Q_W       = DIV_STEPS;
   localparam int LATENCY   = 4 + DIV_STEPS;
   localparam logic [16:0] SCREEN_MAX = 17'h1FFFF;

   typedef enum logic [1:0] {
      REASON_NONE     = 2'd0,
      REASON_VIEWPORT = 2'd1,
      REASON_W        = 2'd2,
      REASON_BOX      = 2'd3
   } reason_type;

   typedef enum logic [2:0] {
      REG_CLIP_X = 3'd0,
      REG_CLIP_Y = 3'd1,
      REG_CLIP_Z = 3'd2,
      REG_CLIP_W = 3'd3,
      REG_ORIGIN = 3'd4,
      REG_SIZE   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic        visible;
      reason_type  reject_reason;
      logic [16:0] screen_x;
      logic [16:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic [RR_W-1:0] rr;
      logic [Q_W-1:0]  q;
   } div_acc_type;

   // one bit of floor(t * k / d): shift, reduce, add t when the k bit is set, reduce
   function automatic div_acc_type div_step(div_acc_type acc, logic [D_W-1:0] r,
                                            logic [D_W-1:0] d, logic kbit);
      div_acc_type nxt;
      logic [RR_W-1:0] dd;
      dd = {1'b0, d};
      nxt.rr = {acc.rr[RR_W-2:0], 1'b0};
      nxt.q  = {acc.q[Q_W-2:0], 1'b0};
      if (nxt.rr >= dd) begin
         nxt.rr = nxt.rr - dd;
         nxt.q  = nxt.q + 1'b1;
      end
      if (kbit) begin
         nxt.rr = nxt.rr + {1'b0, r};
         if (nxt.rr >= dd) begin
            nxt.rr = nxt.rr - dd;
            nxt.q  = nxt.q + 1'b1;
         end
      end
      return nxt;
   endfunction

endpackage

FILE: hw/rtl/world_to_viewport_projection.sv
// Top level: fixed point world to viewport projection pipeline
//
//   channel   ports                          transfer
//   request   start, busy, req_data          start high and busy low at a clock edge
//   result    rsp_valid, rsp_data            one cycle strobe, no back-pressure
//   config    psel..pready (64 bit, APB)     psel, penable, pwrite, pready high
//
// One point enters every cycle; busy is always low. Each result is registered
// through matrix products, clip sums, reject tests, then 20 stages of a
// bit-per-stage divider for the screen fraction, then saturation.
// Synchronous reset clears the registers and the valid bits of all stages,
// dropping points in flight. The receiver cannot stall, so nothing waits.
`timescale 1ns / 1ps

module world_to_viewport_projection
   import w2vp_pkg::*;
#(
   parameter int COORD_FRAC_BITS  = 16,
   parameter int MATRIX_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam longint unsigned EPS =
      ((64'd1 << (COORD_FRAC_BITS + MATRIX_FRAC_BITS)) + 64'd5000) / 64'd10000;
   localparam logic signed [CLIP_W-1:0] EPS_CLIP = CLIP_W'(EPS);

   // configuration registers
   logic [63:0] col_ff [4];
   logic [31:0] origin_ff, size_ff;
   logic [2:0]  reg_idx;
   logic        csr_write;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign reg_idx   = paddr[5:3];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 4; c++) col_ff[c] <= '0;
         origin_ff <= '0;
         size_ff   <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_CLIP_X: col_ff[0] <= pwdata;
            REG_CLIP_Y: col_ff[1] <= pwdata;
            REG_CLIP_Z: col_ff[2] <= pwdata;
            REG_CLIP_W: col_ff[3] <= pwdata;
            REG_ORIGIN: origin_ff <= pwdata[31:0];
            REG_SIZE:   size_ff   <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CLIP_X: prdata = col_ff[0];
         REG_CLIP_Y: prdata = col_ff[1];
         REG_CLIP_Z: prdata = col_ff[2];
         REG_CLIP_W: prdata = col_ff[3];
         REG_ORIGIN: prdata = {32'd0, origin_ff};
         REG_SIZE:   prdata = {32'd0, size_ff};
         default:    prdata = '0;
      endcase
   end

   logic [15:0] vw, vh;
   assign vw = size_ff[15:0];
   assign vh = size_ff[31:16];

   // stage 1: products
   logic                     s1_valid_ff;
   logic                     s1_small_ff;
   logic signed [47:0]       s1_prod_ff [4][3];
   logic signed [CLIP_W-1:0] s1_bias_ff [4];

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      s1_small_ff <= (vw <= 16'd1) || (vh <= 16'd1);
      for (int c = 0; c < 4; c++) begin
         s1_prod_ff[c][0] <= 48'($signed(req_data.world_x) * $signed(col_ff[c][15:0]));
         s1_prod_ff[c][1] <= 48'($signed(req_data.world_y) * $signed(col_ff[c][31:16]));
         s1_prod_ff[c][2] <= 48'($signed(req_data.world_z) * $signed(col_ff[c][47:32]));
         s1_bias_ff[c]    <= CLIP_W'($signed(col_ff[c][63:48])) <<< COORD_FRAC_BITS;
      end
   end

   // stage 2: clip components
   logic                     s2_valid_ff, s2_small_ff;
   logic signed [CLIP_W-1:0] s2_clip_ff [4];

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_small_ff <= s1_small_ff;
      for (int c = 0; c < 4; c++) begin
         s2_clip_ff[c] <= CLIP_W'(s1_prod_ff[c][0]) + CLIP_W'(s1_prod_ff[c][1])
                        + CLIP_W'(s1_prod_ff[c][2]) + s1_bias_ff[c];
      end
   end

   // stage 3: reject tests and divider operands
   logic                     s3_valid_ff;
   reason_type               s3_reason_ff, s3_reason_in;
   logic [D_W-1:0]           s3_tx_ff, s3_ty_ff, s3_d_ff;
   logic [Q_W-1:0]           s3_kx_ff, s3_ky_ff;
   logic signed [CLIP_W-1:0] cx, cy, cz, cw;

   assign cx = s2_clip_ff[0];
   assign cy = s2_clip_ff[1];
   assign cz = s2_clip_ff[2];
   assign cw = s2_clip_ff[3];

   always_comb begin
      if (s2_small_ff)
         s3_reason_in = REASON_VIEWPORT;
      else if (cw <= EPS_CLIP)
         s3_reason_in = REASON_W;
      else if (cx < -cw || cx > cw || cy < -cw || cy > cw || cz < 0 || cz > cw)
         s3_reason_in = REASON_BOX;
      else
         s3_reason_in = REASON_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      s3_reason_ff <= s3_reason_in;
      s3_tx_ff     <= D_W'(cx + cw);
      s3_ty_ff     <= D_W'(cw - cy);
      s3_d_ff      <= {cw, 1'b0};
      s3_kx_ff     <= {vw, 4'd0};
      s3_ky_ff     <= {vh, 4'd0};
   end

   // divider stages, one quotient bit each, most significant first
   typedef struct packed {
      logic           valid;
      reason_type     reason;
      div_acc_type    acc_x;
      div_acc_type    acc_y;
      logic [D_W-1:0] tx;
      logic [D_W-1:0] ty;
      logic [D_W-1:0] d;
      logic [Q_W-1:0] kx;
      logic [Q_W-1:0] ky;
   } div_stage_type;

   div_stage_type div_ff [DIV_STEPS];
   div_stage_type div_in [DIV_STEPS];

   always_comb begin
      div_in[0].valid  = s3_valid_ff;
      div_in[0].reason = s3_reason_ff;
      div_in[0].tx     = s3_tx_ff;
      div_in[0].ty     = s3_ty_ff;
      div_in[0].d      = s3_d_ff;
      div_in[0].kx     = s3_kx_ff;
      div_in[0].ky     = s3_ky_ff;
      div_in[0].acc_x  = div_step('0, s3_tx_ff, s3_d_ff, s3_kx_ff[Q_W-1]);
      div_in[0].acc_y  = div_step('0, s3_ty_ff, s3_d_ff, s3_ky_ff[Q_W-1]);
      for (int j = 1; j < DIV_STEPS; j++) begin
         div_in[j]       = div_ff[j-1];
         div_in[j].acc_x = div_step(div_ff[j-1].acc_x, div_ff[j-1].tx, div_ff[j-1].d,
                                    div_ff[j-1].kx[Q_W-1-j]);
         div_in[j].acc_y = div_step(div_ff[j-1].acc_y, div_ff[j-1].ty, div_ff[j-1].d,
                                    div_ff[j-1].ky[Q_W-1-j]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (reset) div_ff[j] <= '0;
         else       div_ff[j] <= div_in[j];
      end
   end

   // output stage: origin offset and saturation
   div_stage_type last;
   logic [20:0]   sx_sum, sy_sum;
   rsp_type       rsp_in, rsp_ff;
   logic          rsp_valid_ff;

   assign last   = div_ff[DIV_STEPS-1];
   assign sx_sum = {1'b0, origin_ff[15:0], 4'd0} + 21'(last.acc_x.q);
   assign sy_sum = {1'b0, origin_ff[31:16], 4'd0} + 21'(last.acc_y.q);

   always_comb begin
      rsp_in = '0;
      rsp_in.reject_reason = last.reason;
      if (last.reason == REASON_NONE) begin
         rsp_in.visible  = 1'b1;
         rsp_in.screen_x = (sx_sum > 21'(SCREEN_MAX)) ? SCREEN_MAX : sx_sum[16:0];
         rsp_in.screen_y = (sy_sum > 21'(SCREEN_MAX)) ? SCREEN_MAX : sy_sum[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= last.valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/w2vp_checker.sv
// Port level checks for the projection block, bound to the top level
`timescale 1ns / 1ps
`include "world_to_viewport_projection_assert.svh"

module w2vp_checker
   import w2vp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data,
   input logic    pready
);

   `W2VP_ASSERT(a_result_follows, start && !busy |-> ##LATENCY rsp_valid, "result missing")
   `W2VP_ASSERT(a_no_stray_result, rsp_valid |-> $past(start && !busy, LATENCY), "stray result")
   `W2VP_ASSERT(a_visible_code, rsp_valid |-> (rsp_data.visible == (rsp_data.reject_reason == REASON_NONE)), "visible flag disagrees with reason")
   `W2VP_ASSERT(a_rejected_zero, rsp_valid && !rsp_data.visible |-> rsp_data.screen_x == '0 && rsp_data.screen_y == '0, "rejected point carries a position")
   `W2VP_ASSERT_ALWAYS(a_always_ready, !busy && pready, "block not ready")

endmodule

bind world_to_viewport_projection w2vp_checker u_w2vp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

FILE: dv/world_to_viewport_projection_tb.sv
// Self-checking testbench for the world to viewport projection block
`timescale 1ns / 1ps

module world_to_viewport_projection_tb;
   import w2vp_pkg::*;

   localparam int  COORD_FRAC = 16;
   localparam int  MATRIX_FRAC = 12;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic [15:0] ONE_Q12 = 16'sd4096;

   class projection_scoreboard;
      logic [63:0] clip_col[4];
      logic [31:0] origin;
      logic [31:0] size;
      rsp_type     pending_q[$];
      int          mismatches;

      function new();
         foreach (clip_col[i]) clip_col[i] = '0;
         origin = '0;
         size = '0;
         mismatches = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [63:0] val);
         case (idx)
            REG_ORIGIN: origin = val[31:0];
            REG_SIZE:   size = val[31:0];
            default:    clip_col[idx[1:0]] = val;
         endcase
      endfunction

      function longint clip_sum(logic [63:0] col, longint x, longint y, longint z);
         longint m0, m1, m2, m3;
         m0 = longint'($signed(col[15:0]));
         m1 = longint'($signed(col[31:16]));
         m2 = longint'($signed(col[47:32]));
         m3 = longint'($signed(col[63:48]));
         return x * m0 + y * m1 + z * m2 + (m3 <<< COORD_FRAC);
      endfunction

      // floor(t * k / d), clamped to k once t reaches d
      function longint unsigned pixel_frac(longint unsigned t, longint unsigned k,
                                           longint unsigned d);
         logic [127:0] p;
         if (t >= d) return k;
         p = 128'(t) * 128'(k);
         return longint'(p / 128'(d));
      endfunction

      function void note_point(req_type r);
         rsp_type e;
         longint x, y, z, cx, cy, cz, cw, eps;
         longint unsigned vw, vh, sx, sy;
         x = longint'(r.world_x);
         y = longint'(r.world_y);
         z = longint'(r.world_z);
         vw = size[15:0];
         vh = size[31:16];
         eps = ((longint'(1) <<< (COORD_FRAC + MATRIX_FRAC)) + 5000) / 10000;
         e = '0;
         e.reject_reason = REASON_NONE;
         if (vw <= 1 || vh <= 1) begin
            e.reject_reason = REASON_VIEWPORT;
         end else begin
            cx = clip_sum(clip_col[REG_CLIP_X], x, y, z);
            cy = clip_sum(clip_col[REG_CLIP_Y], x, y, z);
            cz = clip_sum(clip_col[REG_CLIP_Z], x, y, z);
            cw = clip_sum(clip_col[REG_CLIP_W], x, y, z);
            if (cw <= eps) begin
               e.reject_reason = REASON_W;
            end else if (cx < -cw || cx > cw || cy < -cw || cy > cw || cz < 0 || cz > cw) begin
               e.reject_reason = REASON_BOX;
            end else begin
               sx = origin[15:0] * 16 + pixel_frac(cx + cw, vw * 16, 2 * cw);
               sy = origin[31:16] * 16 + pixel_frac(cw - cy, vh * 16, 2 * cw);
               e.visible = 1'b1;
               e.screen_x = (sx > SCREEN_MAX) ? SCREEN_MAX : sx[16:0];
               e.screen_y = (sy > SCREEN_MAX) ? SCREEN_MAX : sy[16:0];
            end
         end
         pending_q.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending_q.pop_front();
         if (got.visible !== e.visible || got.reject_reason !== e.reject_reason ||
             got.screen_x !== e.screen_x || got.screen_y !== e.screen_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected vis=%0d why=%0d x=%0d y=%0d, got vis=%0d why=%0d x=%0d y=%0d",
                        e.visible, e.reject_reason, e.screen_x, e.screen_y,
                        got.visible, got.reject_reason, got.screen_x, got.screen_y);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;
   int          cycles = 0;

   projection_scoreboard sb = new();

   world_to_viewport_projection uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // transfers are sampled before this edge's updates land
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) sb.note_point(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 6'(idx * 8);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, val);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic send_point(req_type r);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] pack_col(logic [15:0] m0, logic [15:0] m1,
                                            logic [15:0] m2, logic [15:0] m3);
      return {m3, m2, m1, m0};
   endfunction

   // mostly points inside the frustum of the simple camera, some raw noise
   function automatic req_type random_point();
      req_type r;
      longint z;
      if ($urandom_range(99) < 75) begin
         z = longint'($urandom_range(1, 32'h4000_0000));
         r.world_z = 32'(z);
         r.world_x = 32'(longint'($urandom_range(0, 32'(2 * z + 2))) - z - 1);
         r.world_y = 32'(longint'($urandom_range(0, 32'(2 * z + 2))) - z - 1);
      end else begin
         r.world_x = $urandom;
         r.world_y = $urandom;
         r.world_z = $urandom;
      end
      return r;
   endfunction

   task automatic random_run(int n, int idle_pct);
      int sent;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end else begin
            send_point(random_point());
            sent++;
         end
      end
      drain();
   endtask

   task automatic simple_camera(logic [31:0] org, logic [31:0] dims);
      // x and y pass through, z halved for depth, w = z
      write_reg(REG_CLIP_X, pack_col(ONE_Q12, 16'd0, 16'd0, 16'd0));
      write_reg(REG_CLIP_Y, pack_col(16'd0, ONE_Q12, 16'd0, 16'd0));
      write_reg(REG_CLIP_Z, pack_col(16'd0, 16'd0, 16'sd2048, 16'd0));
      write_reg(REG_CLIP_W, pack_col(16'd0, 16'd0, ONE_Q12, 16'd0));
      write_reg(REG_ORIGIN, 64'(org));
      write_reg(REG_SIZE, 64'(dims));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: viewport too small
      send_point('{32'sd0, 32'sd0, 32'sd65536});
      drain();

      simple_camera({16'd20, 16'd10}, {16'd480, 16'd640});
      send_point('{32'sd0, 32'sd0, 32'sd65536});            // centre
      send_point('{32'sd65536, 32'sd65536, 32'sd65536});    // corner
      send_point('{-32'sd65536, -32'sd65536, 32'sd65536});  // opposite corner
      send_point('{32'sd65537, 32'sd0, 32'sd65536});        // just outside in x
      send_point('{32'sd0, -32'sd65537, 32'sd65536});       // just outside in y
      send_point('{32'sd0, 32'sd0, 32'sd0});                // w zero
      send_point('{32'sd0, 32'sd0, 32'sd6});                // w just under epsilon
      send_point('{32'sd0, 32'sd0, 32'sd7});                // w just over epsilon
      send_point('{32'sd0, 32'sd0, -32'sd65536});           // behind the camera
      send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_point('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
      send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      drain();
      write_reg(REG_SIZE, 64'({16'd480, 16'd1}));
      send_point('{32'sd0, 32'sd0, 32'sd65536});
      drain();
      write_reg(REG_SIZE, 64'({16'd1, 16'd480}));
      send_point('{32'sd0, 32'sd0, 32'sd65536});
      drain();
      // saturation at the far corner
      write_reg(REG_ORIGIN, 64'h0000_0000_FFFF_FFFF);
      write_reg(REG_SIZE, 64'h0000_0000_FFFF_FFFF);
      send_point('{32'sd65536, -32'sd65536, 32'sd65536});
      send_point('{-32'sd65536, 32'sd65536, 32'sd65536});
      drain();

      simple_camera({16'd20, 16'd10}, {16'd480, 16'd640});
      random_run(175, 0);

      write_reg(REG_CLIP_X, {$urandom, $urandom});
      write_reg(REG_CLIP_Y, {$urandom, $urandom});
      write_reg(REG_CLIP_Z, {$urandom, $urandom});
      write_reg(REG_CLIP_W, {$urandom, $urandom});
      write_reg(REG_ORIGIN, {32'd0, $urandom});
      write_reg(REG_SIZE, {32'd0, $urandom});
      random_run(175, 66);

      write_reg(REG_CLIP_X, 64'h7FFF_8000_7FFF_8000);
      write_reg(REG_CLIP_Y, 64'h8000_7FFF_8000_7FFF);
      write_reg(REG_CLIP_Z, 64'h0000_0000_7FFF_0000);
      write_reg(REG_CLIP_W, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(REG_ORIGIN, 64'h0000_0000_FFFF_FFFF);
      write_reg(REG_SIZE, 64'h0000_0000_FFFF_FFFF);
      random_run(175, 0);

      simple_camera(32'h0, {16'd2, 16'd2});
      random_run(175, 17);

      repeat (LATENCY + 10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
